// ===== sv/spq_pkg.sv =====
package spq_pkg;

  // Default number of record cells.
  localparam int CAPACITY_DEF = 16;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_PEEK  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Field widths.
  localparam int PID_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int MEM_W   = 16;
  localparam int COUNT_W = 5;
  localparam int TOTAL_W = 20;

  // Saturation limits of the reported count and memory sum.
  localparam int COUNT_SAT = 31;
  localparam int TOTAL_SAT = 1048575;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // One stored process record.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [MEM_W-1:0]  memory;
  } rec_t;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  spq_pkg::rec_t     new_rec,
  input  logic              left_gt,
  input  spq_pkg::rec_t     left_rec,
  input  spq_pkg::rec_t     right_rec,
  output logic              gt,
  output spq_pkg::rec_t     rec
);

  spq_pkg::rec_t rec_next;

  // An empty cell or one with a larger priority gives way to the new record.
  assign gt = !occ || (rec.prio > new_rec.prio);

  // On push a yielding cell takes its left neighbor, or the new record at the
  // boundary; on pop every cell takes its right neighbor.
  always_comb begin
    rec_next = rec;
    if (ctl.push) begin
      if (gt) begin
        rec_next = left_gt ? left_rec : new_rec;
      end
    end else if (ctl.pop) begin
      rec_next = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ===== sv/stable_priority_queue.sv =====
// Sorted priority queue of process records built as a row of cells.
// Input channel s_*: one beat is one operation (push, pop, peek, clear).
// Output channel m_*: exactly one result beat for every input beat, in order.
// Records leave in ascending priority; equal priorities leave in arrival
// order, since a pushed record lands after every stored record of equal
// priority. Each cell compares its record with the pushed one at once, so
// an operation completes in the cycle it is accepted.
// The result beat is registered and becomes valid in the cycle after the input beat is accepted.
// Throughput: one operation per cycle while m_tready is high.
// A single output register holds the result; when the receiver stalls it
// keeps the beat and s_tready drops, until the beat is taken. s_tready is
// high whenever the output register is empty or being read in that cycle.
// Reset (rst, synchronous) empties the queue, zeroes the memory sum and
// drops m_tvalid; record cells are not cleared and are never read until
// written by a push.
// A full push or an empty pop or peek reports ok low and leaves the state.
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // func[1:0], new_pid[17:2], new_prio[25:18], new_memory[41:26], zero pad
  input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ok[0], out_pid[16:1], out_prio[24:17], out_memory[40:25],
  // entry_count[45:41], is_empty[46], memory_total[66:47], zero pad
  output logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = spq_pkg::MEM_W + CW;

  logic                 accept;
  logic [1:0]           func;
  spq_pkg::rec_t        new_rec;
  spq_pkg::cell_ctl_t   ctl;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [SW-1:0]        mem_sum;
  logic [SW-1:0]        mem_sum_next;
  logic                 full;
  logic                 empty;
  logic                 ok_next;
  spq_pkg::rec_t        out_rec_next;
  logic [spq_pkg::COUNT_W-1:0] ecount_next;
  logic [spq_pkg::TOTAL_W-1:0] total_next;

  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  gt;
  spq_pkg::rec_t        recs [CAPACITY];

  // Input decode.
  assign accept  = s_tvalid && s_tready;
  assign func    = s_tdata[1:0];
  assign new_rec = '{pid: s_tdata[17:2], prio: s_tdata[25:18], memory: s_tdata[41:26]};
  assign full    = (32'(count) >= 32'(CAPACITY));
  assign empty   = (count == '0);

  assign ctl.push = accept && (func == spq_pkg::FUNC_PUSH) && !full;
  assign ctl.pop  = accept && (func == spq_pkg::FUNC_POP) && !empty;

  // Row of cells, front record in cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::rec_t right_rec;
    logic          left_gt;
    spq_pkg::rec_t left_rec;

    assign occ[i] = (32'(i) < 32'(count));

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_rec = new_rec;
    end else begin : g_mid
      assign left_gt  = gt[i-1];
      assign left_rec = recs[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = recs[i];
    end else begin : g_inner
      assign right_rec = recs[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .new_rec   (new_rec),
      .left_gt   (left_gt),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .gt        (gt[i]),
      .rec       (recs[i])
    );
  end

  // Count, memory sum and result fields for the accepted operation.
  always_comb begin
    count_next   = count;
    mem_sum_next = mem_sum;
    ok_next      = 1'b1;
    out_rec_next = '0;
    unique case (func)
      spq_pkg::FUNC_PUSH: begin
        if (full) begin
          ok_next = 1'b0;
        end else begin
          count_next   = count + CW'(1);
          mem_sum_next = mem_sum + SW'(new_rec.memory);
        end
      end
      spq_pkg::FUNC_POP: begin
        if (empty) begin
          ok_next = 1'b0;
        end else begin
          out_rec_next = recs[0];
          count_next   = count - CW'(1);
          mem_sum_next = mem_sum - SW'(recs[0].memory);
        end
      end
      spq_pkg::FUNC_PEEK: begin
        if (empty) begin
          ok_next = 1'b0;
        end else begin
          out_rec_next = recs[0];
        end
      end
      spq_pkg::FUNC_CLEAR: begin
        count_next   = '0;
        mem_sum_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Saturate the reported figures to their field widths.
  always_comb begin
    if (32'(count_next) > 32'(spq_pkg::COUNT_SAT)) begin
      ecount_next = spq_pkg::COUNT_W'(spq_pkg::COUNT_SAT);
    end else begin
      ecount_next = spq_pkg::COUNT_W'(count_next);
    end
    if (32'(mem_sum_next) > 32'(spq_pkg::TOTAL_SAT)) begin
      total_next = spq_pkg::TOTAL_W'(spq_pkg::TOTAL_SAT);
    end else begin
      total_next = spq_pkg::TOTAL_W'(mem_sum_next);
    end
  end

  // Queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      mem_sum <= '0;
    end else if (accept) begin
      count   <= count_next;
      mem_sum <= mem_sum_next;
    end
  end

  // Output register.
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, total_next, (count_next == '0), ecount_next,
                  out_rec_next.memory, out_rec_next.prio, out_rec_next.pid, ok_next};
    end
  end

`ifndef SYNTHESIS
  // The stored count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(CAPACITY))
    else $error("queue count exceeds capacity");

  // An empty queue holds no memory.
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (mem_sum == '0))
    else $error("memory sum nonzero on empty queue");

  // A push that is not refused grows the queue by one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> (count == $past(count) + CW'(1)))
    else $error("push did not increment count");

  // A result beat with ok low carries no record.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[40:1] == '0))
    else $error("failed result carries a record");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[46] == (m_tdata[45:41] == 5'd0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

// ===== bench/stable_priority_queue_tb.sv =====
`timescale 1ns / 100ps

module stable_priority_queue_tb;

  localparam int DEPTH = spq_pkg::CAPACITY_DEF;
  localparam int IN_PAD_W = spq_pkg::IN_TDATA_W -
                            (2 + spq_pkg::PID_W + spq_pkg::PRIO_W + spq_pkg::MEM_W);
  localparam int OUT_PAD_W = spq_pkg::OUT_TDATA_W -
                             (1 + spq_pkg::PID_W + spq_pkg::PRIO_W + spq_pkg::MEM_W +
                              spq_pkg::COUNT_W + 1 + spq_pkg::TOTAL_W);

  // Operation beat as it sits on s_tdata, lowest field last.
  typedef struct packed {
    logic [IN_PAD_W-1:0]         pad;
    logic [spq_pkg::MEM_W-1:0]   new_memory;
    logic [spq_pkg::PRIO_W-1:0]  new_prio;
    logic [spq_pkg::PID_W-1:0]   new_pid;
    logic [1:0]                  func;
  } op_beat_t;

  // Result beat as it sits on m_tdata, lowest field last.
  typedef struct packed {
    logic [OUT_PAD_W-1:0]         pad;
    logic [spq_pkg::TOTAL_W-1:0]  memory_total;
    logic                         is_empty;
    logic [spq_pkg::COUNT_W-1:0]  entry_count;
    logic [spq_pkg::MEM_W-1:0]    out_memory;
    logic [spq_pkg::PRIO_W-1:0]   out_prio;
    logic [spq_pkg::PID_W-1:0]    out_pid;
    logic                         ok;
  } result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Shadow of the queue contents, front at index 0, and of its memory sum.
  spq_pkg::rec_t held[$];
  int            held_mem_sum = 0;
  result_t       due_results[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int result_index = 0;
  result_t seen_beat;
  result_t due_beat;

  stable_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random according to the current stall rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Apply one operation to the shadow queue and return the result it should give.
  function automatic result_t apply_operation(op_beat_t b);
    result_t       r;
    spq_pkg::rec_t rec;
    int            pos;
    r = '0;
    case (b.func)
      spq_pkg::FUNC_PUSH: begin
        if (held.size() < DEPTH) begin
          rec.pid = b.new_pid;
          rec.prio = b.new_prio;
          rec.memory = b.new_memory;
          // The new record goes in front of the first strictly larger priority.
          pos = held.size();
          for (int i = held.size() - 1; i >= 0; i--) begin
            if (held[i].prio > rec.prio) pos = i;
          end
          held.insert(pos, rec);
          held_mem_sum += rec.memory;
          r.ok = 1'b1;
        end
      end
      spq_pkg::FUNC_POP: begin
        if (held.size() != 0) begin
          rec = held.pop_front();
          held_mem_sum -= rec.memory;
          r.ok = 1'b1;
          r.out_pid = rec.pid;
          r.out_prio = rec.prio;
          r.out_memory = rec.memory;
        end
      end
      spq_pkg::FUNC_PEEK: begin
        if (held.size() != 0) begin
          rec = held[0];
          r.ok = 1'b1;
          r.out_pid = rec.pid;
          r.out_prio = rec.prio;
          r.out_memory = rec.memory;
        end
      end
      spq_pkg::FUNC_CLEAR: begin
        held.delete();
        held_mem_sum = 0;
        r.ok = 1'b1;
      end
    endcase
    r.entry_count = spq_pkg::COUNT_W'((held.size() > spq_pkg::COUNT_SAT) ?
                                      spq_pkg::COUNT_SAT : held.size());
    r.is_empty = (held.size() == 0);
    r.memory_total = spq_pkg::TOTAL_W'((held_mem_sum > spq_pkg::TOTAL_SAT) ?
                                       spq_pkg::TOTAL_SAT : held_mem_sum);
    return r;
  endfunction

  // Present one operation beat, wait for it to be taken, and queue the result it should give.
  task automatic send_op(input logic [1:0] op, input logic [spq_pkg::PID_W-1:0] pid,
                         input logic [spq_pkg::PRIO_W-1:0] prio,
                         input logic [spq_pkg::MEM_W-1:0] mem);
    op_beat_t beat;
    beat = '{pad: '0, new_memory: mem, new_prio: prio, new_pid: pid, func: op};
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due_results.push_back(apply_operation(beat));
  endtask

  // Compare every result beat with the oldest one still due.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_beat = m_tdata;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: unexpected beat %h", result_index, m_tdata);
      end else begin
        due_beat = due_results.pop_front();
        if (seen_beat.ok !== due_beat.ok || seen_beat.out_pid !== due_beat.out_pid ||
            seen_beat.out_prio !== due_beat.out_prio ||
            seen_beat.out_memory !== due_beat.out_memory ||
            seen_beat.entry_count !== due_beat.entry_count ||
            seen_beat.is_empty !== due_beat.is_empty ||
            seen_beat.memory_total !== due_beat.memory_total) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected ok=%b pid=%h prio=%h mem=%h cnt=%0d empty=%b total=%0d",
                     result_index, due_beat.ok, due_beat.out_pid, due_beat.out_prio,
                     due_beat.out_memory, due_beat.entry_count, due_beat.is_empty,
                     due_beat.memory_total);
            $display("result %0d: actual   ok=%b pid=%h prio=%h mem=%h cnt=%0d empty=%b total=%0d",
                     result_index, seen_beat.ok, seen_beat.out_pid, seen_beat.out_prio,
                     seen_beat.out_memory, seen_beat.entry_count, seen_beat.is_empty,
                     seen_beat.memory_total);
          end
        end
      end
      result_index++;
    end
  end

  // Pop, peek and clear while nothing is stored.
  task automatic test_empty_queue();
    send_op(spq_pkg::FUNC_POP, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_op(spq_pkg::FUNC_PEEK, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_op(spq_pkg::FUNC_CLEAR, 16'h0000, 8'h00, 16'h0000);
  endtask

  // Fill to capacity with tied and extreme priorities, try one push too many, then peek.
  task automatic test_fill_and_overflow();
    logic [spq_pkg::PRIO_W-1:0] prio_seq [16] = '{8'h80, 8'h80, 8'hFF, 8'h00, 8'h80, 8'h01,
                                                  8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFE, 8'h00,
                                                  8'h80, 8'h40, 8'hFF, 8'h01};
    for (int i = 0; i < DEPTH; i++)
      send_op(spq_pkg::FUNC_PUSH, (i == DEPTH - 1) ? 16'h0000 : (16'hFFFF >> i),
              prio_seq[i % 16], 16'hFFFF);
    send_op(spq_pkg::FUNC_PUSH, 16'h1234, 8'h00, 16'h0001);
    send_op(spq_pkg::FUNC_PEEK, 16'h0000, 8'h00, 16'h0000);
  endtask

  // Pops from the front show arrival order among equal priorities; clear drops the rest.
  task automatic test_drain_order();
    repeat (3) send_op(spq_pkg::FUNC_POP, 16'h0000, 8'h00, 16'h0000);
    send_op(spq_pkg::FUNC_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random operations that swing between filling and draining the queue,
  // so both the full and the empty boundary are crossed often.
  task automatic run_mixed_traffic(input int n);
    bit                         fill_mode;
    int                         roll;
    logic [1:0]                 op;
    logic [spq_pkg::PRIO_W-1:0] prio;
    fill_mode = 1'b1;
    repeat (n) begin
      if (held.size() >= DEPTH) fill_mode = 1'b0;
      else if (held.size() == 0) fill_mode = 1'b1;
      else if ($urandom_range(0, 99) < 4) fill_mode = !fill_mode;
      roll = $urandom_range(0, 99);
      if (roll < 2) op = spq_pkg::FUNC_CLEAR;
      else if (roll < 10) op = spq_pkg::FUNC_PEEK;
      else if (roll < (fill_mode ? 75 : 30)) op = spq_pkg::FUNC_PUSH;
      else op = spq_pkg::FUNC_POP;
      // Narrow priority ranges make ties common.
      case ($urandom_range(0, 3))
        0: prio = 8'($urandom_range(0, 3));
        1: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: prio = 8'($urandom_range(0, 255));
      endcase
      send_op(op, pick_word(), prio, pick_word());
    end
  endtask

  initial begin
    send_gap_pct = 16;
    recv_stall_pct = 52;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_fill_and_overflow();
    test_drain_order();
    run_mixed_traffic(450);
    send_gap_pct = 52;
    recv_stall_pct = 16;
    run_mixed_traffic(450);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_mixed_traffic(450);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
